// File: src/rtv_pkg.sv
// package: shared types, widths and controller codes for the rolling trade vwap core
`timescale 1ns / 1ps
package rtv_pkg;

	localparam int unsigned WINDOW_DEPTH = 64;
	localparam int unsigned PTR_W        = $clog2(WINDOW_DEPTH);

	localparam int unsigned PRICE_W = 32;
	localparam int unsigned QTY_W   = 24;
	localparam int unsigned FRAC_W  = 16;
	localparam int unsigned VWAP_W  = 48;
	localparam int unsigned RATIO_W = 40;
	localparam int unsigned PROD_W  = PRICE_W + QTY_W;

	localparam int unsigned QSUM_W    = QTY_W + PTR_W;
	localparam int unsigned NSUM_FULL = PROD_W + PTR_W;
	localparam int unsigned NSUM_W    = (NSUM_FULL > 64) ? 64 : NSUM_FULL;
	localparam int unsigned DVD_W     = NSUM_W + FRAC_W;

	// exact sums keep the whole part of the average below 2^32
	localparam int unsigned QUO_W = (NSUM_FULL <= 64) ? (PRICE_W + FRAC_W) : (64 + FRAC_W);
	localparam int unsigned DIV_W = QSUM_W;

	localparam int unsigned RADIX_BITS  = 4;
	localparam int unsigned VWAP_STEPS  = QUO_W / RADIX_BITS;
	localparam int unsigned RATIO_STEPS = RATIO_W / RADIX_BITS;
	localparam int unsigned CNT_W       = $clog2(VWAP_STEPS);

	typedef struct packed {
		logic [PRICE_W-1:0] trade_price;
		logic [QTY_W-1:0]   trade_qty;
		logic               trade_is_buy;
		logic [QTY_W-1:0]   best_bid_qty;
		logic [QTY_W-1:0]   best_ask_qty;
		logic               book_valid;
	} rtv_in_t;

	typedef struct packed {
		logic [VWAP_W-1:0]  window_vwap;
		logic               vwap_valid;
		logic [RATIO_W-1:0] aggressor_ratio;
		logic               ratio_valid;
		logic               ratio_saturated;
	} rtv_out_t;

	typedef struct packed {
		logic [PRICE_W-1:0] price;
		logic [QTY_W-1:0]   qty;
	} rtv_entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SUM,
		ST_VLOAD,
		ST_VDIV,
		ST_RLOAD,
		ST_RDIV,
		ST_OUT
	} rtv_state_t;

	typedef struct packed {
		logic capture;
		logic mul_en;
		logic sum_en;
		logic div_load_v;
		logic div_load_r;
		logic div_step;
		logic vwap_take;
		logic ratio_take;
		logic ratio_eval;
		logic out_load;
	} rtv_cmd_t;

	typedef struct packed {
		logic qsum_zero;
		logic ratio_div;
		logic div_last;
		logic out_free;
	} rtv_sts_t;

endpackage

// File: src/rtv_ctrl.sv
// controller: sequences ring update, shared divider and result hand-off per transaction
`timescale 1ns / 1ps
module rtv_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              trade_valid,
	output logic              trade_stall,
	input  rtv_pkg::rtv_sts_t sts,
	output rtv_pkg::rtv_cmd_t cmd
);

	rtv_pkg::rtv_state_t state_q;
	rtv_pkg::rtv_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rtv_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			rtv_pkg::ST_IDLE: begin
				if (trade_valid) begin
					state_nxt = rtv_pkg::ST_MUL;
				end
			end
			rtv_pkg::ST_MUL:   state_nxt = rtv_pkg::ST_SUM;
			rtv_pkg::ST_SUM:   state_nxt = rtv_pkg::ST_VLOAD;
			rtv_pkg::ST_VLOAD: state_nxt = sts.qsum_zero ? rtv_pkg::ST_RLOAD : rtv_pkg::ST_VDIV;
			rtv_pkg::ST_VDIV: begin
				if (sts.div_last) begin
					state_nxt = rtv_pkg::ST_RLOAD;
				end
			end
			rtv_pkg::ST_RLOAD: state_nxt = sts.ratio_div ? rtv_pkg::ST_RDIV : rtv_pkg::ST_OUT;
			rtv_pkg::ST_RDIV: begin
				if (sts.div_last) begin
					state_nxt = rtv_pkg::ST_OUT;
				end
			end
			rtv_pkg::ST_OUT: begin
				if (sts.out_free) begin
					state_nxt = rtv_pkg::ST_IDLE;
				end
			end
			default: state_nxt = rtv_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			rtv_pkg::ST_IDLE:  cmd.capture = trade_valid;
			rtv_pkg::ST_MUL:   cmd.mul_en  = 1'b1;
			rtv_pkg::ST_SUM:   cmd.sum_en  = 1'b1;
			rtv_pkg::ST_VLOAD: cmd.div_load_v = !sts.qsum_zero;
			rtv_pkg::ST_VDIV: begin
				cmd.div_step  = 1'b1;
				cmd.vwap_take = 1'b1;
			end
			rtv_pkg::ST_RLOAD: begin
				cmd.ratio_eval = 1'b1;
				cmd.div_load_r = sts.ratio_div;
			end
			rtv_pkg::ST_RDIV: begin
				cmd.div_step   = 1'b1;
				cmd.ratio_take = 1'b1;
			end
			rtv_pkg::ST_OUT:   cmd.out_load = sts.out_free;
			default:           cmd = '0;
		endcase
	end

	assign trade_stall = (state_q != rtv_pkg::ST_IDLE);

endmodule

// File: src/rtv_datapath.sv
// datapath: trade ring, running sums, shared radix-16 divider and result register
`timescale 1ns / 1ps
module rtv_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  rtv_pkg::rtv_in_t  trade,
	input  rtv_pkg::rtv_cmd_t cmd,
	output rtv_pkg::rtv_sts_t sts,
	output logic              result_valid,
	input  logic              result_stall,
	output rtv_pkg::rtv_out_t result
);

	rtv_pkg::rtv_entry_t ring_mem [rtv_pkg::WINDOW_DEPTH];

	rtv_pkg::rtv_in_t    in_q;
	rtv_pkg::rtv_entry_t old_q;
	logic [rtv_pkg::PROD_W-1:0] old_prod_q;
	logic [rtv_pkg::PROD_W-1:0] new_prod_q;

	logic [rtv_pkg::PTR_W-1:0]  wp_q;
	logic                       full_q;
	logic [rtv_pkg::QSUM_W-1:0] qsum_q;
	logic [rtv_pkg::NSUM_W-1:0] nsum_q;

	logic [rtv_pkg::VWAP_W-1:0]  held_vwap_q;
	logic [rtv_pkg::RATIO_W-1:0] held_ratio_q;
	logic                        vwap_seen_q;
	logic                        ratio_seen_q;
	logic                        sat_q;

	logic [rtv_pkg::DIV_W-1:0] div_rem_q;
	logic [rtv_pkg::DIV_W-1:0] div_den_q;
	logic [rtv_pkg::QUO_W-1:0] div_quo_q;
	logic [rtv_pkg::CNT_W-1:0] div_cnt_q;
	logic [rtv_pkg::DIV_W-1:0] step_rem;
	logic [rtv_pkg::QUO_W-1:0] step_quo;

	rtv_pkg::rtv_out_t result_q;
	logic              result_valid_q;

	logic [rtv_pkg::QTY_W-1:0]   opp_qty;
	logic [rtv_pkg::QTY_W-1:0]   old_qty_eff;
	logic [rtv_pkg::DVD_W-1:0]   vwap_dvd;
	logic [rtv_pkg::RATIO_W-1:0] ratio_dvd;

	assign opp_qty     = in_q.trade_is_buy ? in_q.best_ask_qty : in_q.best_bid_qty;
	assign old_qty_eff = full_q ? old_q.qty : '0;
	assign vwap_dvd    = {nsum_q, {rtv_pkg::FRAC_W{1'b0}}};
	assign ratio_dvd   = {in_q.trade_qty, {rtv_pkg::FRAC_W{1'b0}}};

	assign sts.qsum_zero = (qsum_q == '0);
	assign sts.ratio_div = in_q.book_valid && (opp_qty != '0);
	assign sts.div_last  = (div_cnt_q == '0);
	assign sts.out_free  = !result_valid_q || !result_stall;

	// ring storage
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			old_q <= ring_mem[wp_q];
		end
		if (cmd.mul_en) begin
			ring_mem[wp_q] <= '{price: in_q.trade_price, qty: in_q.trade_qty};
		end
	end

	// four restoring steps per cycle
	always_comb begin
		logic [rtv_pkg::DIV_W:0] trial;
		step_rem = div_rem_q;
		step_quo = div_quo_q;
		for (int i = 0; i < rtv_pkg::RADIX_BITS; i++) begin
			trial = {step_rem, step_quo[rtv_pkg::QUO_W-1]};
			if (trial >= {1'b0, div_den_q}) begin
				step_rem = rtv_pkg::DIV_W'(trial - {1'b0, div_den_q});
				step_quo = {step_quo[rtv_pkg::QUO_W-2:0], 1'b1};
			end else begin
				step_rem = trial[rtv_pkg::DIV_W-1:0];
				step_quo = {step_quo[rtv_pkg::QUO_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			in_q <= trade;
		end
		if (cmd.mul_en) begin
			old_prod_q <= rtv_pkg::PROD_W'(full_q ? old_q.price : '0)
				* rtv_pkg::PROD_W'(old_qty_eff);
			new_prod_q <= rtv_pkg::PROD_W'(in_q.trade_price) * rtv_pkg::PROD_W'(in_q.trade_qty);
		end
		priority if (cmd.div_load_v) begin
			div_rem_q <= rtv_pkg::DIV_W'(vwap_dvd >> rtv_pkg::QUO_W);
			div_quo_q <= vwap_dvd[rtv_pkg::QUO_W-1:0];
			div_den_q <= qsum_q;
			div_cnt_q <= rtv_pkg::CNT_W'(rtv_pkg::VWAP_STEPS - 1);
		end else if (cmd.div_load_r) begin
			div_rem_q <= '0;
			div_quo_q <= {ratio_dvd, {(rtv_pkg::QUO_W - rtv_pkg::RATIO_W){1'b0}}};
			div_den_q <= rtv_pkg::DIV_W'(opp_qty);
			div_cnt_q <= rtv_pkg::CNT_W'(rtv_pkg::RATIO_STEPS - 1);
		end else if (cmd.div_step) begin
			div_rem_q <= step_rem;
			div_quo_q <= step_quo;
			div_cnt_q <= div_cnt_q - 1'b1;
		end else begin
			div_cnt_q <= div_cnt_q;
		end
		if (cmd.out_load) begin
			result_q <= '{
				window_vwap:     held_vwap_q,
				vwap_valid:      vwap_seen_q,
				aggressor_ratio: held_ratio_q,
				ratio_valid:     ratio_seen_q,
				ratio_saturated: sat_q
			};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q           <= '0;
			full_q         <= 1'b0;
			qsum_q         <= '0;
			nsum_q         <= '0;
			held_vwap_q    <= '0;
			held_ratio_q   <= '0;
			vwap_seen_q    <= 1'b0;
			ratio_seen_q   <= 1'b0;
			sat_q          <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (cmd.capture) begin
				sat_q <= 1'b0;
			end
			if (cmd.sum_en) begin
				qsum_q <= qsum_q - rtv_pkg::QSUM_W'(old_qty_eff)
					+ rtv_pkg::QSUM_W'(in_q.trade_qty);
				nsum_q <= nsum_q - rtv_pkg::NSUM_W'(old_prod_q) + rtv_pkg::NSUM_W'(new_prod_q);
				if (wp_q == rtv_pkg::PTR_W'(rtv_pkg::WINDOW_DEPTH - 1)) begin
					wp_q   <= '0;
					full_q <= 1'b1;
				end else begin
					wp_q <= wp_q + 1'b1;
				end
			end
			if (cmd.vwap_take && sts.div_last) begin
				held_vwap_q <= step_quo[rtv_pkg::VWAP_W-1:0];
				vwap_seen_q <= 1'b1;
			end
			if (cmd.ratio_eval && in_q.book_valid) begin
				ratio_seen_q <= 1'b1;
				if (opp_qty == '0) begin
					held_ratio_q <= '1;
					sat_q        <= 1'b1;
				end
			end
			if (cmd.ratio_take && sts.div_last) begin
				held_ratio_q <= step_quo[rtv_pkg::RATIO_W-1:0];
			end
			if (cmd.out_load) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> (div_rem_q < div_den_q))
		else $error("divider remainder not below divisor");

	a_empty_window: assert property (@(posedge clk) disable iff (!arst_n)
		(qsum_q == '0) |-> (nsum_q == '0))
		else $error("zero window quantity with nonzero notional");

	a_out_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!result_valid_q || !result_stall))
		else $error("result overwritten while still waiting");

endmodule

// File: src/rolling_trade_vwap_core.sv
// top level: rolling window vwap and aggressor ratio core
// sequence: capture, multiply, sum, vwap load, vwap pass of QUO_W/4 steps unless the window
// quantity is zero, ratio load, ratio pass of 10 steps for a valid nonzero opposite, output load
// throughput: one transaction at a time, taken again the cycle after the result enters the
// output register; that load waits on a stalled result; passes share the 4-bit-per-cycle divider
// reset: arst_n clears pointer, window sums, held values and flags; ring contents stay unset
`timescale 1ns / 1ps
module rolling_trade_vwap_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              trade_valid,
	output logic              trade_stall,
	input  rtv_pkg::rtv_in_t  trade,
	output logic              result_valid,
	input  logic              result_stall,
	output rtv_pkg::rtv_out_t result
);

	rtv_pkg::rtv_cmd_t cmd;
	rtv_pkg::rtv_sts_t sts;

	rtv_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.trade_valid (trade_valid),
		.trade_stall (trade_stall),
		.sts         (sts),
		.cmd         (cmd)
	);

	rtv_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.trade        (trade),
		.cmd          (cmd),
		.sts          (sts),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
